FILE: src/ddc_pkg.sv
//------------------------------------------------------------------------------
// ddc_pkg
// Types and constants shared by the disk DMA controller modules.
//------------------------------------------------------------------------------
package ddc_pkg;

  // Operation carried in the input tuser.
  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2
  } op_e;

  // Kind of a result beat, carried in the output tuser.
  typedef enum logic [1:0] {
    KIND_READ_DATA = 2'd0,
    KIND_XFER      = 2'd1,
    KIND_IRQ       = 2'd2
  } kind_e;

  // Architectural control state of the DMA engine.
  typedef enum logic [2:0] {
    CTL_INIT  = 3'd0,
    CTL_WAIT  = 3'd1,
    CTL_READ  = 3'd2,
    CTL_WRITE = 3'd3,
    CTL_DONE  = 3'd4
  } ctl_state_e;

  // Sequencer phase of the controller.
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_DECODE,
    PH_READ_OUT,
    PH_CHECK,
    PH_IRQ,
    PH_BURST
  } phase_e;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DEVICE_TYPE = 2'd0;
  localparam logic [1:0] CFG_VENDOR_ID   = 2'd1;
  localparam logic [1:0] CFG_DISK_SIZE   = 2'd2;

  // Byte register map.
  localparam logic [4:0] REG_DEV_LO    = 5'd0;
  localparam logic [4:0] REG_DEV_HI    = 5'd1;
  localparam logic [4:0] REG_VERSION   = 5'd2;
  localparam logic [4:0] REG_VARIATION = 5'd4;
  localparam logic [4:0] REG_VENDOR    = 5'd5;
  localparam logic [4:0] REG_SIZE_0    = 5'd8;
  localparam logic [4:0] REG_SIZE_3    = 5'd11;
  localparam logic [4:0] REG_DPOS_0    = 5'd12;
  localparam logic [4:0] REG_DPOS_3    = 5'd15;
  localparam logic [4:0] REG_MPOS_0    = 5'd16;
  localparam logic [4:0] REG_MPOS_3    = 5'd19;
  localparam logic [4:0] REG_LEN_0     = 5'd20;
  localparam logic [4:0] REG_LEN_3     = 5'd23;
  localparam logic [4:0] REG_CTRL      = 5'd24;
  localparam logic [4:0] REG_SPARE_0   = 5'd25;
  localparam logic [4:0] REG_SPARE_6   = 5'd31;

  localparam int SPARE_DEPTH = 7;

  localparam logic [7:0] VERSION_VAL   = 8'h01;
  localparam logic [7:0] VARIATION_VAL = 8'h01;

  // Control register encodings.
  localparam logic [7:0] CTL_BIT_IDLE  = 8'h01;
  localparam logic [7:0] CTL_BIT_READ  = 8'h02;
  localparam logic [7:0] CTL_BIT_WRITE = 8'h04;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       capture;
    logic       reg_write;
    logic       tick_add;
    logic       tick_sub;
    logic       advance;
    ctl_state_e ctl_state;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_e  op;
    logic granted;
    logic start_read;
    logic start_write;
    logic acc_fire;
    logic xfer_more;
    logic xfer_final;
  } dp_status_t;

  // Result beat request from the controller.
  typedef struct packed {
    logic  valid;
    kind_e kind;
    logic  last;
    logic  direction;
  } emit_t;

endpackage

FILE: src/ddc_ctrl.sv
//------------------------------------------------------------------------------
// ddc_ctrl
// Controller: sequences each item and holds the DMA control state.
//------------------------------------------------------------------------------
module ddc_ctrl #(
  parameter int BURST_BYTES = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                out_ready_i,
  input  ddc_pkg::dp_status_t status_i,
  output ddc_pkg::dp_cmd_t    cmd_o,
  output ddc_pkg::emit_t      emit_o
);

  localparam int CNT_W = $clog2(BURST_BYTES + 1);

  ddc_pkg::phase_e     phase_q, phase_d;
  ddc_pkg::ctl_state_e ctl_q, ctl_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                burst_go;

  assign burst_go = (cnt_q < CNT_W'(BURST_BYTES)) && status_i.xfer_more;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ddc_pkg::PH_IDLE;
      ctl_q   <= ddc_pkg::CTL_INIT;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      ctl_q   <= ctl_d;
      cnt_q   <= cnt_d;
    end
  end

  // Next state.
  always_comb begin
    phase_d = phase_q;
    ctl_d   = ctl_q;
    cnt_d   = cnt_q;
    case (phase_q)
      ddc_pkg::PH_IDLE: begin
        if (in_valid_i) phase_d = ddc_pkg::PH_DECODE;
      end
      ddc_pkg::PH_DECODE: begin
        case (status_i.op)
          ddc_pkg::OP_READ: phase_d = ddc_pkg::PH_READ_OUT;
          ddc_pkg::OP_WRITE: begin
            phase_d = ddc_pkg::PH_IDLE;
            if (ctl_q == ddc_pkg::CTL_WAIT) begin
              if (status_i.start_read) ctl_d = ddc_pkg::CTL_READ;
              else if (status_i.start_write) ctl_d = ddc_pkg::CTL_WRITE;
            end
          end
          ddc_pkg::OP_TICK: phase_d = ddc_pkg::PH_CHECK;
          default: phase_d = ddc_pkg::PH_IDLE;
        endcase
      end
      ddc_pkg::PH_READ_OUT: begin
        if (out_ready_i) phase_d = ddc_pkg::PH_IDLE;
      end
      ddc_pkg::PH_CHECK: begin
        phase_d = ddc_pkg::PH_IDLE;
        if (status_i.acc_fire) begin
          case (ctl_q)
            ddc_pkg::CTL_INIT, ddc_pkg::CTL_DONE: phase_d = ddc_pkg::PH_IRQ;
            ddc_pkg::CTL_READ, ddc_pkg::CTL_WRITE: begin
              phase_d = ddc_pkg::PH_BURST;
              cnt_d   = '0;
            end
            ddc_pkg::CTL_WAIT: phase_d = ddc_pkg::PH_IDLE;
            default: ctl_d = ddc_pkg::CTL_INIT;
          endcase
        end
      end
      ddc_pkg::PH_IRQ: begin
        if (out_ready_i) begin
          phase_d = ddc_pkg::PH_IDLE;
          if (status_i.granted) ctl_d = ddc_pkg::CTL_WAIT;
        end
      end
      ddc_pkg::PH_BURST: begin
        if (burst_go) begin
          if (out_ready_i) cnt_d = cnt_q + CNT_W'(1);
        end else begin
          // Burst exhausted: the transfer is over unless more bytes remain.
          if (!status_i.xfer_more) ctl_d = ddc_pkg::CTL_DONE;
          phase_d = ddc_pkg::PH_IDLE;
        end
      end
      default: phase_d = ddc_pkg::PH_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready_o        = 1'b0;
    cmd_o             = '0;
    cmd_o.ctl_state   = ctl_q;
    emit_o            = '0;
    emit_o.kind       = ddc_pkg::KIND_READ_DATA;
    emit_o.direction  = (ctl_q == ddc_pkg::CTL_WRITE);
    case (phase_q)
      ddc_pkg::PH_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ddc_pkg::PH_DECODE: begin
        cmd_o.reg_write = (status_i.op == ddc_pkg::OP_WRITE);
        cmd_o.tick_add  = (status_i.op == ddc_pkg::OP_TICK);
      end
      ddc_pkg::PH_READ_OUT: begin
        emit_o.valid = 1'b1;
        emit_o.last  = 1'b1;
      end
      ddc_pkg::PH_CHECK: begin
        cmd_o.tick_sub = status_i.acc_fire;
      end
      ddc_pkg::PH_IRQ: begin
        emit_o.valid = 1'b1;
        emit_o.kind  = ddc_pkg::KIND_IRQ;
        emit_o.last  = 1'b1;
      end
      ddc_pkg::PH_BURST: begin
        if (burst_go) begin
          emit_o.valid  = 1'b1;
          emit_o.kind   = ddc_pkg::KIND_XFER;
          emit_o.last   = status_i.xfer_final || (cnt_q == CNT_W'(BURST_BYTES - 1));
          cmd_o.advance = out_ready_i;
        end
      end
      default: in_ready_o = 1'b0;
    endcase
  end

endmodule

FILE: src/ddc_datapath.sv
//------------------------------------------------------------------------------
// ddc_datapath
// Datapath: item capture, register bank, tick accumulator and DMA pointers.
//------------------------------------------------------------------------------
module ddc_datapath #(
  parameter int TICK_DELAY = 128,
  parameter int REG_BYTES  = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [1:0]          cfg_we_idx_i,
  input  logic                cfg_we_i,
  input  logic [31:0]         cfg_data_i,
  input  ddc_pkg::op_e        op_i,
  input  logic [4:0]          reg_index_i,
  input  logic [7:0]          write_data_i,
  input  logic [15:0]         cycles_i,
  input  logic                irq_granted_i,
  input  ddc_pkg::dp_cmd_t    cmd_i,
  output ddc_pkg::dp_status_t status_o,
  output logic [7:0]          read_data_o,
  output logic [31:0]         disk_pos_o,
  output logic [31:0]         mem_pos_o
);

  // Captured item.
  ddc_pkg::op_e op_q;
  logic [4:0]   idx_q;
  logic [7:0]   wdata_q;
  logic [15:0]  cycles_q;
  logic         granted_q;

  // Configuration.
  logic [15:0] dev_type_q;
  logic [7:0]  vendor_q;
  logic [31:0] disk_size_q;

  // Engine state.
  logic [31:0] acc_q, acc_d;
  logic [31:0] dpos_q, dpos_d;
  logic [31:0] mpos_q, mpos_d;
  logic [31:0] len_q, len_d;
  logic [7:0]  spare_q [ddc_pkg::SPARE_DEPTH];
  logic [2:0]  spare_idx;
  logic        in_bank;

  assign in_bank   = (int'(idx_q) < REG_BYTES);
  assign spare_idx = 3'(idx_q - ddc_pkg::REG_SPARE_0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q      <= op_i;
      idx_q     <= reg_index_i;
      wdata_q   <= write_data_i;
      cycles_q  <= cycles_i;
      granted_q <= irq_granted_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_type_q  <= '0;
      vendor_q    <= '0;
      disk_size_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_we_idx_i)
        ddc_pkg::CFG_DEVICE_TYPE: dev_type_q  <= cfg_data_i[15:0];
        ddc_pkg::CFG_VENDOR_ID:   vendor_q    <= cfg_data_i[7:0];
        ddc_pkg::CFG_DISK_SIZE:   disk_size_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    acc_d  = acc_q;
    dpos_d = dpos_q;
    mpos_d = mpos_q;
    len_d  = len_q;
    if (cmd_i.tick_add) acc_d = acc_q + 32'(cycles_q);
    if (cmd_i.tick_sub) acc_d = acc_q - 32'(TICK_DELAY);
    if (cmd_i.reg_write && in_bank) begin
      case (idx_q) inside
        [ddc_pkg::REG_DPOS_0:ddc_pkg::REG_DPOS_3]: dpos_d[8*idx_q[1:0] +: 8] = wdata_q;
        [ddc_pkg::REG_MPOS_0:ddc_pkg::REG_MPOS_3]: mpos_d[8*idx_q[1:0] +: 8] = wdata_q;
        [ddc_pkg::REG_LEN_0:ddc_pkg::REG_LEN_3]:   len_d[8*idx_q[1:0] +: 8]  = wdata_q;
        default: ;
      endcase
    end
    if (cmd_i.advance) begin
      dpos_d = dpos_q + 32'd1;
      mpos_d = mpos_q + 32'd1;
      len_d  = len_q - 32'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      dpos_q <= '0;
      mpos_q <= '0;
      len_q  <= '0;
      for (int i = 0; i < ddc_pkg::SPARE_DEPTH; i++) spare_q[i] <= '0;
    end else begin
      acc_q  <= acc_d;
      dpos_q <= dpos_d;
      mpos_q <= mpos_d;
      len_q  <= len_d;
      if (cmd_i.reg_write && in_bank && idx_q >= ddc_pkg::REG_SPARE_0) begin
        spare_q[spare_idx] <= wdata_q;
      end
    end
  end

  // Register read multiplexer.
  always_comb begin
    read_data_o = '0;
    if (in_bank) begin
      case (idx_q) inside
        ddc_pkg::REG_DEV_LO:    read_data_o = dev_type_q[7:0];
        ddc_pkg::REG_DEV_HI:    read_data_o = dev_type_q[15:8];
        ddc_pkg::REG_VERSION:   read_data_o = ddc_pkg::VERSION_VAL;
        ddc_pkg::REG_VARIATION: read_data_o = ddc_pkg::VARIATION_VAL;
        ddc_pkg::REG_VENDOR:    read_data_o = vendor_q;
        [ddc_pkg::REG_SIZE_0:ddc_pkg::REG_SIZE_3]:
          read_data_o = disk_size_q[8*idx_q[1:0] +: 8];
        [ddc_pkg::REG_DPOS_0:ddc_pkg::REG_DPOS_3]:
          read_data_o = dpos_q[8*idx_q[1:0] +: 8];
        [ddc_pkg::REG_MPOS_0:ddc_pkg::REG_MPOS_3]:
          read_data_o = mpos_q[8*idx_q[1:0] +: 8];
        [ddc_pkg::REG_LEN_0:ddc_pkg::REG_LEN_3]:
          read_data_o = len_q[8*idx_q[1:0] +: 8];
        ddc_pkg::REG_CTRL: begin
          case (cmd_i.ctl_state)
            ddc_pkg::CTL_WAIT:  read_data_o = '0;
            ddc_pkg::CTL_READ:  read_data_o = ddc_pkg::CTL_BIT_READ;
            ddc_pkg::CTL_WRITE: read_data_o = ddc_pkg::CTL_BIT_WRITE;
            default:            read_data_o = ddc_pkg::CTL_BIT_IDLE;
          endcase
        end
        [ddc_pkg::REG_SPARE_0:ddc_pkg::REG_SPARE_6]: read_data_o = spare_q[spare_idx];
        default: read_data_o = '0;
      endcase
    end
  end

  always_comb begin
    status_o.op          = op_q;
    status_o.granted     = granted_q;
    status_o.start_read  = (idx_q == ddc_pkg::REG_CTRL) && |(wdata_q & ddc_pkg::CTL_BIT_READ);
    status_o.start_write = (idx_q == ddc_pkg::REG_CTRL) && |(wdata_q & ddc_pkg::CTL_BIT_WRITE);
    status_o.acc_fire    = (acc_q >= 32'(TICK_DELAY));
    status_o.xfer_more   = (len_q != '0) && (dpos_q < disk_size_q);
    // With the disk pointer below the size, pointer plus one cannot wrap.
    status_o.xfer_final  = (len_q == 32'd1) || ((dpos_q + 32'd1) == disk_size_q);
  end

  assign disk_pos_o = dpos_q;
  assign mem_pos_o  = mpos_q;

endmodule

FILE: src/disk_dma_controller_core.sv
//------------------------------------------------------------------------------
// disk_dma_controller_core
// Byte-register disk DMA controller with a stream input and a stream output.
//
// Each input beat carries one operation in tuser: a register read, a register
// write or a time tick. A read returns one read-data beat; a write returns
// nothing. A tick adds its cycle count to an accumulator; when the accumulator
// has reached at least TICK_DELAY the tick fires. In the init or done state a
// firing tick returns one interrupt-request beat and moves to wait if the
// grant flag was set. In the read or write state it returns up to BURST_BYTES
// transfer-command beats, one per cycle unless the receiver stalls, each with
// disk and memory addresses. tlast marks the final beat caused by an input
// beat. One item is worked on at a time: the sequencer does not take a new
// input beat until it is through with the last one. The output register lets
// the next beat be presented while the previous one waits; when the receiver
// stalls, the sequencer holds and nothing is lost. Reset returns the engine
// to the init state with all pointers, the accumulator and the configuration
// at zero. Configuration writes are taken at any edge with the write enable
// high.
//------------------------------------------------------------------------------
module disk_dma_controller_core #(
  parameter int TICK_DELAY  = 128,
  parameter int BURST_BYTES = 16,
  parameter int REG_BYTES   = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // reg_index[4:0], write_data[12:5],
                                     // cycles[28:13], irq_granted[29]
  input  logic [1:0]  s_axis_tuser,  // opcode[1:0]
  // Output stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,  // read_data[7:0], disk_address[39:8],
                                     // memory_address[71:40], direction[72]
  output logic [1:0]  m_axis_tuser,  // kind[1:0]
  output logic        m_axis_tlast
);

  ddc_pkg::dp_cmd_t    cmd;
  ddc_pkg::dp_status_t status;
  ddc_pkg::emit_t      emit;

  logic [7:0]  read_data;
  logic [31:0] disk_pos;
  logic [31:0] mem_pos;
  logic        out_ready;
  logic        out_load;

  // Output register state.
  logic        out_valid_q;
  logic [1:0]  out_kind_q;
  logic        out_last_q;
  logic [7:0]  out_rd_q;
  logic [31:0] out_da_q;
  logic [31:0] out_ma_q;
  logic        out_dir_q;

  ddc_ctrl #(
    .BURST_BYTES(BURST_BYTES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_ready_i(out_ready),
    .status_i   (status),
    .cmd_o      (cmd),
    .emit_o     (emit)
  );

  ddc_datapath #(
    .TICK_DELAY(TICK_DELAY),
    .REG_BYTES (REG_BYTES)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_idx_i (cfg_index_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .op_i         (ddc_pkg::op_e'(s_axis_tuser)),
    .reg_index_i  (s_axis_tdata[4:0]),
    .write_data_i (s_axis_tdata[12:5]),
    .cycles_i     (s_axis_tdata[28:13]),
    .irq_granted_i(s_axis_tdata[29]),
    .cmd_i        (cmd),
    .status_o     (status),
    .read_data_o  (read_data),
    .disk_pos_o   (disk_pos),
    .mem_pos_o    (mem_pos)
  );

  // The output register takes a new beat whenever it is empty or being drained.
  assign out_ready = !out_valid_q || m_axis_tready;
  assign out_load  = emit.valid && out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= emit.valid;
    end
  end

  // Fields that have no meaning for a beat's kind are sent as zero.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_kind_q <= emit.kind;
      out_last_q <= emit.last;
      out_rd_q   <= (emit.kind == ddc_pkg::KIND_READ_DATA) ? read_data : 8'd0;
      out_da_q   <= (emit.kind == ddc_pkg::KIND_XFER) ? disk_pos : 32'd0;
      out_ma_q   <= (emit.kind == ddc_pkg::KIND_XFER) ? mem_pos : 32'd0;
      out_dir_q  <= (emit.kind == ddc_pkg::KIND_XFER) && emit.direction;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {7'd0, out_dir_q, out_ma_q, out_da_q, out_rd_q};

endmodule
